>>> src/clg_pkg.sv
// Shared types, constants and register map of the crop level governor.
package clg_pkg;

  localparam int BUCKET_COUNT_DEF  = 4;
  localparam int COVERAGE_BITS_DEF = 16;

  localparam int FRAME_ID_W   = 32;
  localparam int COV_FIELD_W  = 16;
  localparam int BUCKET_SLOT  = 16;
  localparam int BLEND_W      = 5;
  localparam int DOWN_W       = 5;
  localparam int UP_W         = 8;
  localparam int DWELL_W      = 10;
  localparam int APB_DATA_W   = 64;
  localparam int APB_ADDR_W   = 6;

  localparam logic [DOWN_W-1:0]  DOWN_MIN  = 5'd1;
  localparam logic [DOWN_W-1:0]  DOWN_MAX  = 5'd16;
  localparam logic [UP_W-1:0]    UP_MIN    = 8'd8;
  localparam logic [UP_W-1:0]    UP_MAX    = 8'd240;
  localparam logic [DWELL_W-1:0] DWELL_MIN = 10'd8;
  localparam logic [DWELL_W-1:0] DWELL_MAX = 10'd600;
  localparam logic [BLEND_W-1:0] BLEND_MIN = 5'd2;
  localparam logic [BLEND_W-1:0] BLEND_MAX = 5'd24;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_BUCKET_TABLE = 3'd1,
    REG_MAX_COVERAGE = 3'd2,
    REG_MIN_COVERAGE = 3'd3,
    REG_DOWN_FRAMES  = 3'd4,
    REG_UP_FRAMES    = 3'd5,
    REG_DWELL_FRAMES = 3'd6,
    REG_BLEND_FRAMES = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                   enable;
    logic [APB_DATA_W-1:0]  bucket_table;
    logic [COV_FIELD_W-1:0] max_coverage;
    logic [COV_FIELD_W-1:0] min_coverage;
    logic [DOWN_W-1:0]      down_frames;
    logic [UP_W-1:0]        up_frames;
    logic [DWELL_W-1:0]     dwell_frames;
    logic [BLEND_W-1:0]     blend_frames;
    logic                   dirty;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_ID_W-1:0] frame_id;
    logic                  eligible;
    logic                  geometry_ok;
    logic                  eye_tracking_on;
    logic                  allow_down;
    logic                  renderer_moving;
    logic                  renderer_at_max;
    logic                  over_budget;
    logic                  has_headroom;
  } in_item_t;

  typedef struct packed {
    logic                   skipped;
    logic                   running;
    logic                   eye_blocked;
    logic                   geometry_blocked;
    logic [COV_FIELD_W-1:0] active_coverage;
    logic [COV_FIELD_W-1:0] upper_coverage;
    logic [COV_FIELD_W-1:0] lower_coverage;
    logic [BLEND_W-1:0]     blend_position;
    logic [BLEND_W-1:0]     blend_length;
  } out_item_t;

endpackage

>>> src/clg_in_if.sv
// Input channel: one frame report per beat.
interface clg_in_if;
  import clg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FRAME_ID_W-1:0] frame_id;
  logic                  eligible;
  logic                  geometry_ok;
  logic                  eye_tracking_on;
  logic                  allow_down;
  logic                  renderer_moving;
  logic                  renderer_at_max;
  logic                  over_budget;
  logic                  has_headroom;

  modport source (
    output valid, frame_id, eligible, geometry_ok, eye_tracking_on, allow_down,
           renderer_moving, renderer_at_max, over_budget, has_headroom,
    input  ready
  );

  modport sink (
    input  valid, frame_id, eligible, geometry_ok, eye_tracking_on, allow_down,
           renderer_moving, renderer_at_max, over_budget, has_headroom,
    output ready
  );
endinterface

>>> src/clg_out_if.sv
// Output channel: one level decision per beat.
interface clg_out_if;
  import clg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   skipped;
  logic                   running;
  logic                   eye_blocked;
  logic                   geometry_blocked;
  logic [COV_FIELD_W-1:0] active_coverage;
  logic [COV_FIELD_W-1:0] upper_coverage;
  logic [COV_FIELD_W-1:0] lower_coverage;
  logic [BLEND_W-1:0]     blend_position;
  logic [BLEND_W-1:0]     blend_length;

  modport source (
    output valid, skipped, running, eye_blocked, geometry_blocked, active_coverage,
           upper_coverage, lower_coverage, blend_position, blend_length,
    input  ready
  );

  modport sink (
    input  valid, skipped, running, eye_blocked, geometry_blocked, active_coverage,
           upper_coverage, lower_coverage, blend_position, blend_length,
    output ready
  );
endinterface

>>> src/clg_cfg_regs.sv
// APB register file with write saturation and change tracking.
module clg_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [clg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [clg_pkg::APB_DATA_W-1:0]  prdata,
  input  logic                            dirty_clear,
  output clg_pkg::cfg_t                   cfg
);
  import clg_pkg::*;

  reg_idx_t            idx;
  logic                wr;
  logic [DOWN_W-1:0]   down_raw, down_sat;
  logic [UP_W-1:0]     up_raw, up_sat;
  logic [DWELL_W-1:0]  dwell_raw, dwell_sat;
  logic [BLEND_W-1:0]  blend_raw, blend_sat;
  logic                dirty_set;

  assign idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign wr  = psel & penable & pwrite;

  assign down_raw  = pwdata[DOWN_W-1:0];
  assign up_raw    = pwdata[UP_W-1:0];
  assign dwell_raw = pwdata[DWELL_W-1:0];
  assign blend_raw = pwdata[BLEND_W-1:0];

  assign down_sat  = (down_raw < DOWN_MIN) ? DOWN_MIN :
                     ((down_raw > DOWN_MAX) ? DOWN_MAX : down_raw);
  assign up_sat    = (up_raw < UP_MIN) ? UP_MIN : ((up_raw > UP_MAX) ? UP_MAX : up_raw);
  assign dwell_sat = (dwell_raw < DWELL_MIN) ? DWELL_MIN :
                     ((dwell_raw > DWELL_MAX) ? DWELL_MAX : dwell_raw);
  assign blend_sat = (blend_raw < BLEND_MIN) ? BLEND_MIN :
                     ((blend_raw > BLEND_MAX) ? BLEND_MAX : blend_raw);

  // only the control registers mark a change here; table and bounds are
  // compared at frame time after rounding
  always_comb begin
    dirty_set = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_ENABLE:       dirty_set = (pwdata[0] != cfg.enable);
        REG_DOWN_FRAMES:  dirty_set = (down_sat != cfg.down_frames);
        REG_UP_FRAMES:    dirty_set = (up_sat != cfg.up_frames);
        REG_DWELL_FRAMES: dirty_set = (dwell_sat != cfg.dwell_frames);
        REG_BLEND_FRAMES: dirty_set = (blend_sat != cfg.blend_frames);
        REG_BUCKET_TABLE, REG_MAX_COVERAGE, REG_MIN_COVERAGE: dirty_set = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.bucket_table <= '0;
      cfg.max_coverage <= '0;
      cfg.min_coverage <= '0;
      cfg.down_frames  <= DOWN_MIN;
      cfg.up_frames    <= UP_MIN;
      cfg.dwell_frames <= DWELL_MIN;
      cfg.blend_frames <= BLEND_MIN;
      cfg.dirty        <= 1'b1;
    end else begin
      if (wr) begin
        unique case (idx)
          REG_ENABLE:       cfg.enable       <= pwdata[0];
          REG_BUCKET_TABLE: cfg.bucket_table <= pwdata;
          REG_MAX_COVERAGE: cfg.max_coverage <= pwdata[COV_FIELD_W-1:0];
          REG_MIN_COVERAGE: cfg.min_coverage <= pwdata[COV_FIELD_W-1:0];
          REG_DOWN_FRAMES:  cfg.down_frames  <= down_sat;
          REG_UP_FRAMES:    cfg.up_frames    <= up_sat;
          REG_DWELL_FRAMES: cfg.dwell_frames <= dwell_sat;
          REG_BLEND_FRAMES: cfg.blend_frames <= blend_sat;
        endcase
      end
      // a set wins over a clear
      if (dirty_set) begin
        cfg.dirty <= 1'b1;
      end else if (dirty_clear) begin
        cfg.dirty <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:       prdata = APB_DATA_W'(cfg.enable);
      REG_BUCKET_TABLE: prdata = cfg.bucket_table;
      REG_MAX_COVERAGE: prdata = APB_DATA_W'(cfg.max_coverage);
      REG_MIN_COVERAGE: prdata = APB_DATA_W'(cfg.min_coverage);
      REG_DOWN_FRAMES:  prdata = APB_DATA_W'(cfg.down_frames);
      REG_UP_FRAMES:    prdata = APB_DATA_W'(cfg.up_frames);
      REG_DWELL_FRAMES: prdata = APB_DATA_W'(cfg.dwell_frames);
      REG_BLEND_FRAMES: prdata = APB_DATA_W'(cfg.blend_frames);
    endcase
  end
endmodule

>>> src/clg_ctrl.sv
// Level decision state and its update for one frame.
module clg_ctrl #(
  parameter int BUCKET_COUNT  = clg_pkg::BUCKET_COUNT_DEF,
  parameter int COVERAGE_BITS = clg_pkg::COVERAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  clg_pkg::in_item_t  item,
  input  clg_pkg::cfg_t      cfg,
  output logic               dirty_clear,
  output clg_pkg::out_item_t result
);
  import clg_pkg::*;

  localparam int IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

  logic [COVERAGE_BITS-1:0] bkt [BUCKET_COUNT];

  // state
  logic [FRAME_ID_W-1:0]    last_frame,     last_frame_next;
  logic [COVERAGE_BITS-1:0] prev_min,       prev_min_next;
  logic                     is_running,     is_running_next;
  logic [IDX_W-1:0]         level_index,    level_index_next;
  logic [IDX_W-1:0]         upper_index,    upper_index_next;
  logic [IDX_W-1:0]         lower_index,    lower_index_next;
  logic [BLEND_W-1:0]       blend_pos,      blend_pos_next;
  logic [BLEND_W-1:0]       blend_len,      blend_len_next;
  logic [DWELL_W-1:0]       dwell_count,    dwell_count_next;
  logic [DOWN_W-1:0]        overrun_count,  overrun_count_next;
  logic [UP_W-1:0]          headroom_count, headroom_count_next;
  logic [1:0]               blocked_flags,  blocked_flags_next;

  // bucket search
  logic                     max_found, min_found;
  logic [IDX_W-1:0]         max_idx, min_idx, last_eq_idx, lo_idx, upper, lower;
  logic [COVERAGE_BITS-1:0] min_b;
  logic                     is_repeat, changed, geom_blocked, run_ok;

  always_comb begin
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      bkt[i] = cfg.bucket_table[BUCKET_SLOT*i +: COVERAGE_BITS];
    end
  end

  always_comb begin
    max_found   = 1'b0;
    min_found   = 1'b0;
    max_idx     = LAST_IDX;
    min_idx     = LAST_IDX;
    last_eq_idx = LAST_IDX;
    for (int i = BUCKET_COUNT - 1; i >= 0; i--) begin
      if (COV_FIELD_W'(bkt[i]) <= cfg.max_coverage) begin
        max_found = 1'b1;
        max_idx   = IDX_W'(i);
      end
      if (COV_FIELD_W'(bkt[i]) <= cfg.min_coverage) begin
        min_found = 1'b1;
        min_idx   = IDX_W'(i);
      end
      if (bkt[i] == bkt[BUCKET_COUNT-1]) begin
        last_eq_idx = IDX_W'(i);
      end
    end
    upper = max_found ? max_idx : last_eq_idx;
    min_b = min_found ? bkt[min_idx] : bkt[BUCKET_COUNT-1];
  end

  // index of the rounded minimum; always hits since min_b is a bucket
  always_comb begin
    lo_idx = LAST_IDX;
    for (int i = BUCKET_COUNT - 1; i >= 0; i--) begin
      if (bkt[i] <= min_b) begin
        lo_idx = IDX_W'(i);
      end
    end
    lower = (lo_idx > upper) ? lo_idx : upper;
  end

  assign is_repeat    = (item.frame_id == last_frame);
  assign changed      = cfg.dirty || (min_b != prev_min) || (upper != upper_index);
  assign geom_blocked = !item.geometry_ok || (cfg.max_coverage < COV_FIELD_W'(bkt[BUCKET_COUNT-1]));
  assign run_ok       = item.eligible && cfg.enable && !item.eye_tracking_on && !geom_blocked;

  always_comb begin
    last_frame_next     = last_frame;
    prev_min_next       = prev_min;
    is_running_next     = is_running;
    level_index_next    = level_index;
    upper_index_next    = upper_index;
    lower_index_next    = lower_index;
    blend_pos_next      = blend_pos;
    blend_len_next      = blend_len;
    dwell_count_next    = dwell_count;
    overrun_count_next  = overrun_count;
    headroom_count_next = headroom_count;
    blocked_flags_next  = blocked_flags;
    dirty_clear         = 1'b0;

    if (fire && !is_repeat) begin
      last_frame_next    = item.frame_id;
      prev_min_next      = min_b;
      dirty_clear        = 1'b1;
      upper_index_next   = upper;
      lower_index_next   = lower;
      blocked_flags_next = {geom_blocked, item.eye_tracking_on};

      if (!run_ok) begin
        is_running_next     = 1'b0;
        level_index_next    = '0;
        upper_index_next    = '0;
        lower_index_next    = LAST_IDX;
        blend_pos_next      = '0;
        blend_len_next      = '0;
        dwell_count_next    = '0;
        overrun_count_next  = '0;
        headroom_count_next = '0;
      end else begin
        is_running_next = 1'b1;
        if (changed) begin
          level_index_next    = upper;
          blend_pos_next      = '0;
          blend_len_next      = '0;
          dwell_count_next    = '0;
          overrun_count_next  = '0;
          headroom_count_next = '0;
        end
        if (level_index_next < upper) begin
          level_index_next = upper;
        end else if (level_index_next > lower) begin
          level_index_next = lower;
        end

        if (blend_len_next != '0) begin
          if ((BLEND_W+1)'(blend_pos_next) + 1'b1 >= (BLEND_W+1)'(blend_len_next)) begin
            blend_pos_next = '0;
            blend_len_next = '0;
          end else begin
            blend_pos_next = blend_pos_next + 1'b1;
          end
        end

        if (dwell_count_next != '1) begin
          dwell_count_next = dwell_count_next + 1'b1;
        end

        if (item.renderer_moving) begin
          overrun_count_next  = '0;
          headroom_count_next = '0;
        end else begin
          priority if (item.over_budget) begin
            if (overrun_count_next != '1) begin
              overrun_count_next = overrun_count_next + 1'b1;
            end
            headroom_count_next = '0;
          end else if (item.has_headroom) begin
            overrun_count_next = '0;
            if (item.renderer_at_max) begin
              if (headroom_count_next != '1) begin
                headroom_count_next = headroom_count_next + 1'b1;
              end
            end else begin
              headroom_count_next = '0;
            end
          end else begin
            overrun_count_next  = '0;
            headroom_count_next = '0;
          end

          // step down takes precedence over step up
          priority if (dwell_count_next >= cfg.dwell_frames && item.allow_down &&
                       overrun_count_next >= cfg.down_frames && level_index_next < lower) begin
            level_index_next    = level_index_next + 1'b1;
            blend_pos_next      = '0;
            blend_len_next      = cfg.blend_frames;
            dwell_count_next    = '0;
            overrun_count_next  = '0;
            headroom_count_next = '0;
          end else if (dwell_count_next >= cfg.dwell_frames && item.renderer_at_max &&
                       headroom_count_next >= cfg.up_frames && level_index_next > upper) begin
            level_index_next    = level_index_next - 1'b1;
            blend_pos_next      = '0;
            blend_len_next      = cfg.blend_frames;
            dwell_count_next    = '0;
            overrun_count_next  = '0;
            headroom_count_next = '0;
          end else begin
            level_index_next = level_index_next;
          end
        end
      end
    end
  end

  always_comb begin
    result.skipped          = is_repeat;
    result.running          = is_running_next;
    result.eye_blocked      = blocked_flags_next[0];
    result.geometry_blocked = blocked_flags_next[1];
    result.active_coverage  = COV_FIELD_W'(bkt[level_index_next]);
    result.upper_coverage   = COV_FIELD_W'(bkt[upper_index_next]);
    result.lower_coverage   = COV_FIELD_W'(bkt[lower_index_next]);
    result.blend_position   = blend_pos_next;
    result.blend_length     = blend_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame     <= '1;
      prev_min       <= '0;
      is_running     <= 1'b0;
      level_index    <= '0;
      upper_index    <= '0;
      lower_index    <= LAST_IDX;
      blend_pos      <= '0;
      blend_len      <= '0;
      dwell_count    <= '0;
      overrun_count  <= '0;
      headroom_count <= '0;
      blocked_flags  <= '0;
    end else begin
      last_frame     <= last_frame_next;
      prev_min       <= prev_min_next;
      is_running     <= is_running_next;
      level_index    <= level_index_next;
      upper_index    <= upper_index_next;
      lower_index    <= lower_index_next;
      blend_pos      <= blend_pos_next;
      blend_len      <= blend_len_next;
      dwell_count    <= dwell_count_next;
      overrun_count  <= overrun_count_next;
      headroom_count <= headroom_count_next;
      blocked_flags  <= blocked_flags_next;
    end
  end

  a_level_in_bounds: assert property (@(posedge clk) disable iff (rst)
    is_running |-> (level_index >= upper_index && level_index <= lower_index))
    else $error("level outside its bounds while running");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    lower_index >= upper_index)
    else $error("lower level above upper level");

  a_blend_pos: assert property (@(posedge clk) disable iff (rst)
    (blend_len != '0) |-> (blend_pos < blend_len))
    else $error("transition position past its length");

  a_idle_cleared: assert property (@(posedge clk) disable iff (rst)
    !is_running |-> (level_index == '0 && blend_len == '0 && dwell_count == '0))
    else $error("decision state not cleared while stopped");

  a_repeat_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && is_repeat) |=> $stable(level_index) && $stable(dwell_count))
    else $error("repeated frame changed the state");
endmodule

>>> src/crop_level_governor.sv
// Top level of the crop level governor: register file, input and result stages.
//
//  channel | dir | beat / access
//  --------+-----+---------------------------------------------------------
//  in_ch   | in  | one frame report: frame_id plus eight status flags
//  out_ch  | out | one decision: flags, three coverages, transition pos/len
//  apb     | in  | 64-bit registers at 8*index, write at psel&penable&pwrite
//
// A beat goes through two registers, the input stage and then the result
// register. Throughput is one beat per cycle while out_ch is ready; the
// level update is a single pass through a BUCKET_COUNT-entry bucket search
// (four by default) and the counter compares. No clearing pass: everything
// is usable straight after the synchronous reset. A stalled result register
// holds the input stage; an empty input stage takes a beat even then.
module crop_level_governor #(
  parameter int BUCKET_COUNT  = clg_pkg::BUCKET_COUNT_DEF,
  parameter int COVERAGE_BITS = clg_pkg::COVERAGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  clg_in_if.sink                         in_ch,
  clg_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [clg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [clg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [clg_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import clg_pkg::*;

  cfg_t      cfg;
  logic      dirty_clear;

  // input stage
  logic      s1_valid;
  in_item_t  s1_item;
  in_item_t  in_item;
  logic      s1_adv;
  logic      s1_fire;
  logic      in_fire;

  // result stage
  logic      res_valid;
  out_item_t res;
  out_item_t step_result;

  assign pready = 1'b1;

  clg_cfg_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .dirty_clear (dirty_clear),
    .cfg         (cfg)
  );

  assign in_item.frame_id        = in_ch.frame_id;
  assign in_item.eligible        = in_ch.eligible;
  assign in_item.geometry_ok     = in_ch.geometry_ok;
  assign in_item.eye_tracking_on = in_ch.eye_tracking_on;
  assign in_item.allow_down      = in_ch.allow_down;
  assign in_item.renderer_moving = in_ch.renderer_moving;
  assign in_item.renderer_at_max = in_ch.renderer_at_max;
  assign in_item.over_budget     = in_ch.over_budget;
  assign in_item.has_headroom    = in_ch.has_headroom;

  // the input stage moves on whenever the result register is free or draining
  assign s1_adv      = !res_valid || out_ch.ready;
  assign s1_fire     = s1_valid && s1_adv;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_item;
    end
  end

  // state update happens on the same edge that loads the result
  clg_ctrl #(
    .BUCKET_COUNT  (BUCKET_COUNT),
    .COVERAGE_BITS (COVERAGE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .item        (s1_item),
    .cfg         (cfg),
    .dirty_clear (dirty_clear),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= s1_fire || (res_valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= step_result;
    end
  end

  assign out_ch.valid            = res_valid;
  assign out_ch.skipped          = res.skipped;
  assign out_ch.running          = res.running;
  assign out_ch.eye_blocked      = res.eye_blocked;
  assign out_ch.geometry_blocked = res.geometry_blocked;
  assign out_ch.active_coverage  = res.active_coverage;
  assign out_ch.upper_coverage   = res.upper_coverage;
  assign out_ch.lower_coverage   = res.lower_coverage;
  assign out_ch.blend_position   = res.blend_position;
  assign out_ch.blend_length     = res.blend_length;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_ch.ready) |-> !s1_fire)
    else $error("result register overwritten while stalled");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("input stage dropped a stalled beat");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> res_valid)
    else $error("input stage advanced without a result");
endmodule
